### src/s2l_pkg.sv
`timescale 1ns / 1ps

package s2l_pkg;

    localparam int LIN_W   = 25;
    localparam int COEF_W  = 20;
    localparam int PROD_W  = 45;
    localparam int SUM_W   = 47;
    localparam int XYZ_W   = 25;
    localparam int XYZ_SH  = 20;
    localparam int F_W     = 25;
    localparam int CBRT_W  = 25;
    localparam int SLOPE_W = 24;
    localparam int TL_W    = 18;
    localparam int N_W     = 31;
    localparam int DIV_K   = 41;
    localparam int Q_W     = 21;
    localparam int LV_W    = 33;
    localparam int AV_W    = 35;
    localparam int Q24     = 24;

    localparam logic [SUM_W-1:0]  XYZ_RND   = SUM_W'(64'd1 << (XYZ_SH - 1));
    localparam logic [31:0]       DIV_M     = 32'(((64'd1 << DIV_K) + 64'd999) / 64'd1000);
    localparam logic [12:0]       LIN_SLOPE = 13'd7787;
    localparam logic [8:0]        LIN_BIAS  = 9'd500;
    localparam logic [XYZ_W-1:0]  THRESH24  =
        XYZ_W'(((64'd8856 << 24) + 64'd500000) / 64'd1000000);
    localparam logic [F_W-1:0]    K16_24    = F_W'(((64'd16 << 24) + 64'd58) / 64'd116);
    localparam logic [LV_W-1:0]   L_OFFSET  = LV_W'(64'd16 << 24);
    localparam logic [6:0]        L_SCALE   = 7'd116;
    localparam logic [8:0]        A_SCALE   = 9'd500;
    localparam logic [7:0]        B_SCALE   = 8'd200;

    localparam logic [COEF_W-1:0] C_XR = COEF_W'(((64'd41240 << 20) + 64'd47523) / 64'd95047);
    localparam logic [COEF_W-1:0] C_XG = COEF_W'(((64'd35760 << 20) + 64'd47523) / 64'd95047);
    localparam logic [COEF_W-1:0] C_XB = COEF_W'(((64'd18050 << 20) + 64'd47523) / 64'd95047);
    localparam logic [COEF_W-1:0] C_YR = COEF_W'(((64'd2126 << 20) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] C_YG = COEF_W'(((64'd7152 << 20) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] C_YB = COEF_W'(((64'd722 << 20) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] C_ZR = COEF_W'(((64'd1930 << 20) + 64'd54441) / 64'd108883);
    localparam logic [COEF_W-1:0] C_ZG = COEF_W'(((64'd11920 << 20) + 64'd54441) / 64'd108883);
    localparam logic [COEF_W-1:0] C_ZB = COEF_W'(((64'd95050 << 20) + 64'd54441) / 64'd108883);

    typedef logic [COEF_W-1:0] t_coef_mat [3][3];
    localparam t_coef_mat MAT = '{
        '{C_XR, C_XG, C_XB},
        '{C_YR, C_YG, C_YB},
        '{C_ZR, C_ZG, C_ZB}
    };

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       last_in;
    } t_pix_in;

    typedef struct packed {
        logic [14:0]        lightness;
        logic signed [15:0] green_red;
        logic signed [15:0] blue_yellow;
        logic               last_out;
    } t_lab_out;

    function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b,
                                         input int q);
        return ((a * b) + (64'd1 << (q - 1))) >> q;
    endfunction

    function automatic logic [63:0] pow5_30(input logic [63:0] v);
        logic [63:0] v2;
        v2 = mulq(v, v, 30);
        return mulq(mulq(v2, v2, 30), v, 30);
    endfunction

    function automatic logic [CBRT_W-1:0] cbrt_q24(input logic [63:0] t);
        logic [63:0] lo, hi, mid;
        lo = 64'd0;
        hi = 64'd1 << Q24;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            if (mulq(mulq(mid, mid, Q24), mid, Q24) <= t) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        return CBRT_W'(lo);
    endfunction

    function automatic logic [LIN_W-1:0] gamma_entry(input int unsigned c);
        logic [63:0] s, u, lo, hi, mid;
        if (c <= 10) begin
            return LIN_W'((((64'(c) * 64'd100) << 24) + 64'd164730) / 64'd329460);
        end
        s  = ((64'(1000 * c + 14025) << 30) + 64'd134512) / 64'd269025;
        u  = mulq(s, s, 30);
        lo = 64'd0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            if (pow5_30(mid) <= u) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        return LIN_W'((mulq(u, lo, 30) + 64'd32) >> 6);
    endfunction

    typedef logic [LIN_W-1:0] t_gamma_tab [256];

    function automatic t_gamma_tab build_gamma();
        t_gamma_tab tab;
        for (int c = 0; c < 256; c++) begin
            tab[c] = gamma_entry(c);
        end
        return tab;
    endfunction

    localparam t_gamma_tab GAMMA_TAB = build_gamma();

endpackage

### src/s2l_lab_f.sv
`timescale 1ns / 1ps

module s2l_lab_f
    import s2l_pkg::*;
#(
    parameter int CBRT_TABLE_BITS = 10
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [XYZ_W-1:0] i_t,
    output logic [F_W-1:0]   o_f
);

    localparam int SEG_SHIFT = Q24 - CBRT_TABLE_BITS;
    localparam int ROM_N     = 2 ** CBRT_TABLE_BITS;
    localparam int ROM_W     = CBRT_W + SLOPE_W;
    localparam int IDX_W     = XYZ_W - SEG_SHIFT;
    localparam int FRAC_W    = SEG_SHIFT + 2;
    localparam int IP_W      = SLOPE_W + FRAC_W + 1;
    localparam int INT_W     = IP_W - SEG_SHIFT;
    localparam logic [IP_W-1:0] SEG_HALF = IP_W'(64'd1 << (SEG_SHIFT - 1));

    typedef logic [ROM_W-1:0] t_rom [ROM_N];

    // entry i: {cbrt(i), cbrt(i+1) - cbrt(i)}
    function automatic t_rom build_rom();
        t_rom        rom;
        logic [CBRT_W-1:0] cur, nxt;
        cur = cbrt_q24(64'd0);
        for (int i = 0; i < ROM_N; i++) begin
            nxt    = cbrt_q24(64'(i + 1) << SEG_SHIFT);
            rom[i] = {cur, SLOPE_W'(nxt - cur)};
            cur    = nxt;
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [IDX_W-1:0]           n_idx;
    logic [CBRT_TABLE_BITS-1:0] n_addr;
    logic [FRAC_W-1:0]          n_frac;

    logic [ROM_W-1:0]  r_word;
    logic [FRAC_W-1:0] r_frac;
    logic              r_sel;
    logic [N_W-1:0]    r_n;
    logic              r_sel2;
    logic [Q_W-1:0]    r_q;
    logic [CBRT_W-1:0] r_base;
    logic [INT_W-1:0]  r_interp;
    logic [F_W-1:0]    r_f;

    assign n_idx  = i_t[XYZ_W-1:SEG_SHIFT];
    // above one: extrapolate the last segment
    assign n_addr = n_idx[CBRT_TABLE_BITS] ? '1 : n_idx[CBRT_TABLE_BITS-1:0];
    assign n_frac = FRAC_W'(i_t - XYZ_W'({n_addr, {SEG_SHIFT{1'b0}}}));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word   <= ROM[n_addr];
            r_frac   <= n_frac;
            r_sel    <= (i_t <= THRESH24);
            r_n      <= N_W'(i_t[TL_W-1:0]) * N_W'(LIN_SLOPE) + N_W'(LIN_BIAS);

            r_sel2   <= r_sel;
            r_q      <= Q_W'((64'(r_n) * 64'(DIV_M)) >> DIV_K);
            r_base   <= r_word[ROM_W-1 -: CBRT_W];
            r_interp <= INT_W'((IP_W'(r_word[SLOPE_W-1:0]) * IP_W'(r_frac) + SEG_HALF)
                               >> SEG_SHIFT);

            r_f      <= r_sel2 ? F_W'(r_q) + K16_24 : r_base + F_W'(r_interp);
        end
    end

    assign o_f = r_f;

endmodule

### src/srgb_to_cielab.sv
// sRGB (8 bits per component) to CIELAB, D65 white, one pixel per clock when the output
// is not stalled; nine register stages: gamma table, 3x3 matrix multiply, matrix sum,
// three stages of f() (cube-root ROM read and interpolation, linear segment), Lab scaling,
// rounding, and the output register. Each of the three f() units holds a cube-root ROM of
// 2^CBRT_TABLE_BITS words read once per pixel. A stall on the output holds every stage.
// L, a and b carry OUT_FRAC_BITS fraction bits; a and b saturate to 16 bits.
`timescale 1ns / 1ps

module srgb_to_cielab
    import s2l_pkg::*;
#(
    parameter int OUT_FRAC_BITS   = 8,
    parameter int CBRT_TABLE_BITS = 10
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_pix_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_lab_out o_out_data
);

    localparam int LAT  = 9;
    localparam int RS   = Q24 - OUT_FRAC_BITS;
    localparam int LQ_W = LV_W - RS;
    localparam int AQ_W = (AV_W - RS > 17) ? AV_W - RS : 17;
    localparam logic [LV_W-1:0] LV_HALF = LV_W'(64'd1 << (RS - 1));
    localparam logic [AV_W-1:0] AV_HALF = AV_W'(64'd1 << (RS - 1));
    localparam logic [14:0]     L_MAX   = 15'(100 << OUT_FRAC_BITS);
    localparam logic [AQ_W-1:0] POS_MAX = AQ_W'(32767);
    localparam logic [AQ_W-1:0] NEG_MAX = AQ_W'(32768);

    logic             en;
    logic [7:0]       n_rgb [3];
    logic [F_W-1:0]   w_f [3];
    logic [AV_W-1:0]  n_amag, n_bmag;

    logic [LAT-1:0]         r_vld;
    logic [LAT-2:0]         r_last;
    logic [LIN_W-1:0]       r_lin  [3];
    logic [PROD_W-1:0]      r_prod [3][3];
    logic [XYZ_W-1:0]       r_xyz  [3];
    logic signed [LV_W-1:0] r_lv;
    logic signed [AV_W-1:0] r_av, r_bv;
    logic [LQ_W-1:0]        r_lq;
    logic [AQ_W-1:0]        r_aq, r_bq;
    logic                   r_aneg, r_bneg;
    t_lab_out               r_out;

    assign en         = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready = en;

    assign n_rgb[0] = i_in_data.red_in;
    assign n_rgb[1] = i_in_data.green_in;
    assign n_rgb[2] = i_in_data.blue_in;

    assign n_amag = r_av[AV_W-1] ? AV_W'(0) - AV_W'(r_av) : AV_W'(r_av);
    assign n_bmag = r_bv[AV_W-1] ? AV_W'(0) - AV_W'(r_bv) : AV_W'(r_bv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last <= {r_last[LAT-3:0], i_in_data.last_in};

            for (int k = 0; k < 3; k++) begin
                r_lin[k] <= GAMMA_TAB[n_rgb[k]];
            end

            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[k][j] <= PROD_W'(MAT[k][j]) * PROD_W'(r_lin[j]);
                end
            end

            for (int k = 0; k < 3; k++) begin
                r_xyz[k] <= XYZ_W'((SUM_W'(r_prod[k][0]) + SUM_W'(r_prod[k][1])
                                    + SUM_W'(r_prod[k][2]) + XYZ_RND) >> XYZ_SH);
            end

            r_lv <= LV_W'(w_f[1]) * LV_W'(L_SCALE) - L_OFFSET;
            r_av <= (AV_W'(w_f[0]) - AV_W'(w_f[1])) * AV_W'(A_SCALE);
            r_bv <= (AV_W'(w_f[1]) - AV_W'(w_f[2])) * AV_W'(B_SCALE);

            r_lq   <= r_lv[LV_W-1] ? '0 : LQ_W'((LV_W'(r_lv) + LV_HALF) >> RS);
            r_aq   <= AQ_W'((n_amag + AV_HALF) >> RS);
            r_bq   <= AQ_W'((n_bmag + AV_HALF) >> RS);
            r_aneg <= r_av[AV_W-1];
            r_bneg <= r_bv[AV_W-1];

            r_out.lightness <= (r_lq > LQ_W'(L_MAX)) ? L_MAX : 15'(r_lq);
            if (r_aneg) begin
                r_out.green_red <= (r_aq > NEG_MAX) ? 16'sh8000 : 16'(AQ_W'(0) - r_aq);
            end else begin
                r_out.green_red <= (r_aq > POS_MAX) ? 16'sh7fff : 16'(r_aq);
            end
            if (r_bneg) begin
                r_out.blue_yellow <= (r_bq > NEG_MAX) ? 16'sh8000 : 16'(AQ_W'(0) - r_bq);
            end else begin
                r_out.blue_yellow <= (r_bq > POS_MAX) ? 16'sh7fff : 16'(r_bq);
            end
            r_out.last_out <= r_last[LAT-2];
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_f
        s2l_lab_f #(
            .CBRT_TABLE_BITS(CBRT_TABLE_BITS)
        ) u_f (
            .i_clk(i_clk),
            .i_en (en),
            .i_t  (r_xyz[k]),
            .o_f  (w_f[k])
        );
    end

    assign o_out_valid = r_vld[LAT-1];
    assign o_out_data  = r_out;

    a_l_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.lightness <= L_MAX))
        else $error("lightness above 100");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(r_vld))
        else $error("pipeline valid bits moved during stall");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-2] && o_in_ready) |=> o_out_valid)
        else $error("transaction lost before output register");

endmodule
